// File: rtl/uvsg_pkg.sv
package uvsg_pkg;

   // core sizes
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int DIV_BITS      = 10;

   localparam int FRAC_BITS  = (DIV_BITS < ANGLE_BITS - 1) ? DIV_BITS : ANGLE_BITS - 1;
   localparam int NUM_STAGES = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

   // divider: quotient is at most 2^FRAC_BITS, remainder below twice the divisor
   localparam int CFG_DIV_W = 10;
   localparam int Q_W       = FRAC_BITS + 1;
   localparam int REM_W     = CFG_DIV_W + 1;

   // angle word alignment
   localparam int SH_A = ANGLE_BITS - FRAC_BITS;
   localparam int SH_E = ANGLE_BITS - 1 - FRAC_BITS;
   localparam int SH_T = 32 - ANGLE_BITS;

   // cordic datapath, Q2.30 with headroom
   localparam int XY_W  = 34;
   localparam int Z_W   = 33;
   localparam int STG_W = 5;
   localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sh0_26DD_3B6A;

   // register map
   localparam logic [1:0] REG_RADIUS  = 2'd0;
   localparam logic [1:0] REG_COLUMNS = 2'd1;
   localparam logic [1:0] REG_ROWS    = 2'd2;

   localparam logic [15:0] RADIUS_RESET  = 16'd256;
   localparam logic [9:0]  COLUMNS_RESET = 10'd16;
   localparam logic [9:0]  ROWS_RESET    = 10'd16;

   typedef struct packed {
      logic [19:0] vidx;
      logic        starts_cell;
      logic        oor;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [REM_W-1:0] ra;
      logic [REM_W-1:0] re;
      logic [Q_W-1:0]   qa;
      logic [Q_W-1:0]   qe;
   } div_type;

   typedef struct packed {
      logic [1:0]             quad;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cord_lane_type;

   typedef struct packed {
      side_type      side;
      cord_lane_type az;
      cord_lane_type el;
   } cord_type;

   // arctangent of 2^-i as a fraction of a full turn, 32 bits
   function automatic logic [31:0] atan_turn(input logic [STG_W-1:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'h2000_0000;
         5'd1:  a = 32'h12E4_051D;
         5'd2:  a = 32'h09FB_385B;
         5'd3:  a = 32'h0511_11D4;
         5'd4:  a = 32'h028B_0D43;
         5'd5:  a = 32'h0145_D7E1;
         5'd6:  a = 32'h00A2_F61E;
         5'd7:  a = 32'h0051_7C55;
         5'd8:  a = 32'h0028_BE53;
         5'd9:  a = 32'h0014_5F2F;
         5'd10: a = 32'h000A_2F98;
         5'd11: a = 32'h0005_17CC;
         5'd12: a = 32'h0002_8BE6;
         5'd13: a = 32'h0001_45F3;
         5'd14: a = 32'h0000_A2F9;
         5'd15: a = 32'h0000_517C;
         5'd16: a = 32'h0000_28BE;
         5'd17: a = 32'h0000_145F;
         5'd18: a = 32'h0000_0A2F;
         5'd19: a = 32'h0000_0517;
         5'd20: a = 32'h0000_028B;
         5'd21: a = 32'h0000_0145;
         5'd22: a = 32'h0000_00A2;
         5'd23: a = 32'h0000_0051;
         default: a = 32'h0000_0000;
      endcase
      return a;
   endfunction

   // round to nearest at bit 15, clamp to +-32767
   function automatic logic signed [15:0] rnd_q15(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] t;
      logic signed [15:0] r;
      t = (v + 34'sd16384) >>> 15;
      if (t > 34'sd32767)
         r = 16'sd32767;
      else if (t < -34'sd32767)
         r = -16'sd32767;
      else
         r = t[15:0];
      return r;
   endfunction

   // same rounding, clamp to +-65535
   function automatic logic signed [16:0] rnd_pos(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] t;
      logic signed [16:0] r;
      t = (v + 34'sd16384) >>> 15;
      if (t > 34'sd65535)
         r = 17'sd65535;
      else if (t < -34'sd65535)
         r = -17'sd65535;
      else
         r = t[16:0];
      return r;
   endfunction

endpackage

// File: rtl/uvsg_div_cell.sv
module uvsg_div_cell
   import uvsg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CFG_DIV_W-1:0] div_a,
   input  logic [CFG_DIV_W-1:0] div_e,
   input  logic                 in_valid,
   input  div_type              in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output div_type              out_data,
   input  logic                 out_ready
);

   logic             valid_ff, valid_in;
   div_type          data_ff, data_in;
   logic             ge_a, ge_e;
   logic [REM_W-1:0] sub_a, sub_e;

   assign in_ready = !valid_ff || out_ready;

   // one restoring step on both lanes
   always_comb begin
      ge_a  = in_data.ra >= {1'b0, div_a};
      ge_e  = in_data.re >= {1'b0, div_e};
      sub_a = ge_a ? in_data.ra - {1'b0, div_a} : in_data.ra;
      sub_e = ge_e ? in_data.re - {1'b0, div_e} : in_data.re;
      data_in      = in_data;
      data_in.ra   = {sub_a[REM_W-2:0], 1'b0};
      data_in.re   = {sub_e[REM_W-2:0], 1'b0};
      data_in.qa   = {in_data.qa[Q_W-2:0], ge_a};
      data_in.qe   = {in_data.qe[Q_W-2:0], ge_e};
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/uvsg_cordic_cell.sv
module uvsg_cordic_cell
   import uvsg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [STG_W-1:0] stage_idx,
   input  logic             in_valid,
   input  cord_type         in_data,
   output logic             in_ready,
   output logic             out_valid,
   output cord_type         out_data,
   input  logic             out_ready
);

   logic     valid_ff, valid_in;
   cord_type data_ff, data_in;

   function automatic cord_lane_type rotate(input cord_lane_type l,
                                            input logic [STG_W-1:0] s);
      logic signed [XY_W-1:0] x, y, dx, dy;
      logic signed [Z_W-1:0]  z, a;
      cord_lane_type          o;
      x  = l.x;
      y  = l.y;
      z  = l.z;
      dx = y >>> s;
      dy = x >>> s;
      a  = $signed({1'b0, atan_turn(s)});
      o  = l;
      // zero residual counts as positive
      if (!z[Z_W-1]) begin
         o.x = x - dx;
         o.y = y + dy;
         o.z = z - a;
      end else begin
         o.x = x + dx;
         o.y = y - dy;
         o.z = z + a;
      end
      return o;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in      = in_data;
      data_in.az   = rotate(in_data.az, stage_idx);
      data_in.el   = rotate(in_data.el, stage_idx);
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/uvsg_finish.sv
module uvsg_finish
   import uvsg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [15:0]  radius,
   input  logic         in_valid,
   input  cord_type     in_data,
   output logic         in_ready,
   output logic         out_valid,
   output logic [119:0] out_tdata,
   output logic [1:0]   out_tuser,
   input  logic         out_ready
);

   typedef struct packed {
      side_type           side;
      logic signed [15:0] ca;
      logic signed [15:0] sa;
      logic signed [15:0] ce;
      logic signed [15:0] se;
   } trig_type;

   typedef struct packed {
      side_type           side;
      logic signed [31:0] px;
      logic signed [31:0] pz;
      logic signed [15:0] ce;
   } nprod_type;

   typedef struct packed {
      side_type           side;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } norm_type;

   typedef struct packed {
      side_type           side;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [32:0] rx;
      logic signed [32:0] ry;
      logic signed [32:0] rz;
   } pprod_type;

   logic [4:0] valid_ff, valid_in, rdy;

   trig_type   trig_ff, trig_in;
   nprod_type  nprod_ff, nprod_in;
   norm_type   norm_ff, norm_in;
   pprod_type  pprod_ff, pprod_in;
   logic [119:0] tdata_ff, tdata_in;
   logic [1:0]   tuser_ff, tuser_in;

   logic signed [16:0] rad_s;
   logic signed [16:0] ox, oy, oz;

   function automatic void fold(input cord_lane_type l,
                                output logic signed [15:0] c,
                                output logic signed [15:0] s);
      logic signed [XY_W-1:0] cc, ss;
      case (l.quad)
         2'd0: begin cc = l.x;  ss = l.y;  end
         2'd1: begin cc = -l.y; ss = l.x;  end
         2'd2: begin cc = -l.x; ss = -l.y; end
         default: begin cc = l.y; ss = -l.x; end
      endcase
      c = rnd_q15(cc);
      s = rnd_q15(ss);
   endfunction

   // stage k moves when the next stage takes its beat or it is empty
   always_comb begin
      rdy[4] = !valid_ff[4] || out_ready;
      for (int k = 3; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < 5; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign rad_s = $signed({1'b0, radius});

   always_comb begin
      trig_in.side = in_data.side;
      fold(in_data.az, trig_in.ca, trig_in.sa);
      fold(in_data.el, trig_in.ce, trig_in.se);

      nprod_in.side = trig_ff.side;
      nprod_in.px   = 32'(trig_ff.se) * 32'(trig_ff.ca);
      nprod_in.pz   = 32'(trig_ff.se) * 32'(trig_ff.sa);
      nprod_in.ce   = trig_ff.ce;

      norm_in.side = nprod_ff.side;
      norm_in.nx   = rnd_q15(XY_W'(nprod_ff.px));
      norm_in.ny   = nprod_ff.ce;
      norm_in.nz   = rnd_q15(XY_W'(nprod_ff.pz));

      pprod_in.side = norm_ff.side;
      pprod_in.nx   = norm_ff.nx;
      pprod_in.ny   = norm_ff.ny;
      pprod_in.nz   = norm_ff.nz;
      pprod_in.rx   = 33'(rad_s) * 33'(norm_ff.nx);
      pprod_in.ry   = 33'(rad_s) * 33'(norm_ff.ny);
      pprod_in.rz   = 33'(rad_s) * 33'(norm_ff.nz);

      ox = rnd_pos(XY_W'(pprod_ff.rx));
      oy = rnd_pos(XY_W'(pprod_ff.ry));
      oz = rnd_pos(XY_W'(pprod_ff.rz));

      // a point past the grid reports zeros
      if (pprod_ff.side.oor) begin
         tdata_in = '0;
      end else begin
         tdata_in = {1'b0, pprod_ff.side.vidx, pprod_ff.nz, pprod_ff.ny, pprod_ff.nx,
                     oz, oy, ox};
      end
      tuser_in = {pprod_ff.side.oor, pprod_ff.side.starts_cell};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         trig_ff <= trig_in;
      end
      if (rdy[1] && valid_ff[0]) begin
         nprod_ff <= nprod_in;
      end
      if (rdy[2] && valid_ff[1]) begin
         norm_ff <= norm_in;
      end
      if (rdy[3] && valid_ff[2]) begin
         pprod_ff <= pprod_in;
      end
      if (rdy[4] && valid_ff[3]) begin
         tdata_ff <= tdata_in;
         tuser_ff <= tuser_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[4];
   assign out_tdata = tdata_ff;
   assign out_tuser = tuser_ff;

endmodule

// File: rtl/uv_sphere_vertex_generator.sv
// channel | direction | handshake              | payload
// req     | in        | req_tvalid/req_tready  | tdata: col_index, row_index
// rsp     | out       | rsp_tvalid/rsp_tready  | tdata: position, normal, vertex index;
//         |           |                        | tuser: starts_cell, out_of_range
// csr     | in        | apb, pready always 1   | radius @0x0, columns @0x4, rows @0x8
//
// one beat per cycle sustained while rsp_tready is high; the path is FRAC_BITS+1 divider cells,
// NUM_STAGES cordic cells and five finishing stages
// every cell holds one beat and moves it on when its neighbour is free, so bubbles close up
// and req_tready stays high while a result waits on rsp as long as some cell is empty
// reset is synchronous; it empties all cells and loads radius 1.0, 16 columns, 16 rows
module uv_sphere_vertex_generator
   import uvsg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // [9:0] col_index, [19:10] row_index

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z,
                                     // [66:51] norm_x, [82:67] norm_y, [98:83] norm_z,
                                     // [118:99] vertex_index
   output logic [1:0]   rsp_tuser,   // [0] starts_cell, [1] out_of_range

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [15:0] radius_ff, radius_in;
   logic [9:0]  columns_ff, columns_in;
   logic [9:0]  rows_ff, rows_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      radius_in  = radius_ff;
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_RADIUS:  radius_in  = csr_pwdata[15:0];
            REG_COLUMNS: columns_in = csr_pwdata[9:0];
            REG_ROWS:    rows_in    = csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RESET;
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else begin
         radius_ff  <= radius_in;
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_RADIUS:  csr_prdata = {16'd0, radius_ff};
         REG_COLUMNS: csr_prdata = {22'd0, columns_ff};
         REG_ROWS:    csr_prdata = {22'd0, rows_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   // entry: grid flags and linear index
   logic [9:0]  col, row;
   logic [20:0] vidx_full;
   div_type     div_head;

   assign col = req_tdata[9:0];
   assign row = req_tdata[19:10];

   always_comb begin
      vidx_full = 21'({1'b0, columns_ff} + 11'd1) * 21'(row) + 21'(col);
      div_head.side.oor         = (col > columns_ff) || (row > rows_ff);
      div_head.side.starts_cell = !div_head.side.oor && (col < columns_ff) && (row < rows_ff);
      div_head.side.vidx        = div_head.side.oor ? 20'd0 : vidx_full[19:0];
      div_head.ra               = {1'b0, col};
      div_head.re               = {1'b0, row};
      div_head.qa               = '0;
      div_head.qe               = '0;
   end

   // divider chain
   logic    dv_valid [Q_W+1];
   logic    dv_ready [Q_W+1];
   div_type dv_data  [Q_W+1];

   assign dv_valid[0] = req_tvalid;
   assign dv_data[0]  = div_head;
   assign req_tready  = dv_ready[0];

   for (genvar g = 0; g < Q_W; g++) begin : g_div
      uvsg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .div_a     (columns_ff),
         .div_e     (rows_ff),
         .in_valid  (dv_valid[g]),
         .in_data   (dv_data[g]),
         .in_ready  (dv_ready[g]),
         .out_valid (dv_valid[g+1]),
         .out_data  (dv_data[g+1]),
         .out_ready (dv_ready[g+1])
      );
   end

   // quotients to turn fractions, quadrant in the top two bits
   logic [Q_W-1:0]        qa, qe;
   logic [ANGLE_BITS:0]   aw_wide, ew_wide;
   logic [31:0]           turn_a, turn_e;
   cord_type              cd_head;

   always_comb begin
      qa      = (columns_ff == 10'd0) ? '0 : dv_data[Q_W].qa;
      qe      = (rows_ff == 10'd0) ? '0 : dv_data[Q_W].qe;
      aw_wide = (ANGLE_BITS+1)'(qa) << SH_A;
      ew_wide = (ANGLE_BITS+1)'(qe) << SH_E;
      turn_a  = 32'(aw_wide[ANGLE_BITS-1:0]) << SH_T;
      turn_e  = 32'(ew_wide[ANGLE_BITS-1:0]) << SH_T;
      cd_head.side    = dv_data[Q_W].side;
      cd_head.az.quad = turn_a[31:30];
      cd_head.az.x    = CORDIC_X0;
      cd_head.az.y    = '0;
      cd_head.az.z    = $signed({3'b000, turn_a[29:0]});
      cd_head.el.quad = turn_e[31:30];
      cd_head.el.x    = CORDIC_X0;
      cd_head.el.y    = '0;
      cd_head.el.z    = $signed({3'b000, turn_e[29:0]});
   end

   // cordic chain
   logic     cd_valid [NUM_STAGES+1];
   logic     cd_ready [NUM_STAGES+1];
   cord_type cd_data  [NUM_STAGES+1];

   assign cd_valid[0]   = dv_valid[Q_W];
   assign cd_data[0]    = cd_head;
   assign dv_ready[Q_W] = cd_ready[0];

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cordic
      uvsg_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STG_W'(g)),
         .in_valid  (cd_valid[g]),
         .in_data   (cd_data[g]),
         .in_ready  (cd_ready[g]),
         .out_valid (cd_valid[g+1]),
         .out_data  (cd_data[g+1]),
         .out_ready (cd_ready[g+1])
      );
   end

   uvsg_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .in_valid  (cd_valid[NUM_STAGES]),
      .in_data   (cd_data[NUM_STAGES]),
      .in_ready  (cd_ready[NUM_STAGES]),
      .out_valid (rsp_tvalid),
      .out_tdata (rsp_tdata),
      .out_tuser (rsp_tuser),
      .out_ready (rsp_tready)
   );

endmodule
